@@ rtl/linear_probe_hash_table_core_assert.svh @@
// Assertion macros for the linear probe hash table core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define LPHT_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("lpht assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define LPHT_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lpht assertion failed");

`endif

@@ rtl/lpht_pkg.sv @@
// Shared types for the linear probe hash table core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package lpht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HOME,
    S_PROBE,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item
    logic hash;    // register the quotient of value by table size
    logic start;   // set probe index to home slot, clear step count
    logic issue;   // read the slot at the probe index and advance
    logic commit;  // record a hit and, on insert or delete, update the table
    logic fail;    // record a miss or a full table
  } lpht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;        // slot read last cycle satisfies the request
    logic miss;       // last slot read and nothing satisfied
    logic exhausted;  // every slot of the circle has been read
  } lpht_sts_t;

endpackage

`default_nettype wire

@@ rtl/lpht_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpht_ctrl.sv @@
// Controller state machine for the linear probe hash table core.
// Depends on lpht_pkg for state, command and status types.
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      out_stall,
  input  wire lpht_sts_t sts,
  output lpht_cmd_t      cmd,
  output logic           in_stall,
  output logic           out_valid
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.hash   = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        cmd.start  = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        // keep reads flowing; stop on first hit or after the last slot
        cmd.issue = !sts.exhausted;
        if (sts.hit) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else if (sts.miss) begin
          cmd.fail   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

endmodule

`default_nettype wire

@@ rtl/lpht_datapath.sv @@
// Datapath for the linear probe hash table core: home slot hash, probe
// index, slot valid bits, value RAM and result register. Uses lpht_pkg, lpht_ram.
`default_nettype none

module lpht_datapath
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lpht_cmd_t   cmd,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] item_value,
  output lpht_sts_t        sts,
  output logic [1:0]       status,
  output logic [2:0]       slot_index
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  // floor(2^24 / size): quotient estimate is exact or one low for 16-bit values
  localparam int unsigned RECIP = (2 ** 24) / TABLE_SIZE;

  op_t                   op_r;
  logic [15:0]           value;
  logic [15:0]           quot;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_d;
  logic [CW-1:0]         cnt;
  logic                  pend;
  logic                  last_d;
  logic [TABLE_SIZE-1:0] slot_valid;
  status_t               res_status;
  logic [2:0]            res_slot;
  logic [15:0]           rd_data;

  logic [39:0]   quot_prod;
  logic [24:0]   qn;
  logic [16:0]   rem_full;
  logic [9:0]    rem_raw;
  logic [9:0]    rem_fix;
  logic [IW-1:0] home;
  logic [IW-1:0] idx_wrap;
  logic          is_insert;
  logic          is_delete;
  logic          hit;

  assign is_insert = (op_r == OP_INSERT);
  assign is_delete = (op_r == OP_DELETE);

  // Quotient estimate by reciprocal multiply
  assign quot_prod = 40'(value) * 40'(24'(RECIP));

  // Remainder from registered quotient, one correcting subtract
  assign qn       = 25'(quot) * 25'(TABLE_SIZE);
  assign rem_full = {1'b0, value} - qn[16:0];
  assign rem_raw  = rem_full[9:0];
  assign rem_fix  = (rem_raw >= 10'(TABLE_SIZE)) ? rem_raw - 10'(TABLE_SIZE) : rem_raw;
  assign home     = IW'(rem_fix);

  assign idx_wrap = (idx == IW'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;

  // Judge the slot read in the previous cycle
  always_comb begin
    if (is_insert) begin
      hit = pend && !slot_valid[idx_d];
    end else begin
      hit = pend && slot_valid[idx_d] && (rd_data == value);
    end
  end

  assign sts.hit       = hit;
  assign sts.miss      = pend && last_d && !hit;
  assign sts.exhausted = (cnt == CW'(TABLE_SIZE));

  // Item capture, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(operation);
      value <= item_value;
    end
    if (cmd.hash) begin
      quot <= quot_prod[39:24];
    end
    if (cmd.start) begin
      idx <= home;
      cnt <= '0;
    end else if (cmd.issue) begin
      idx    <= idx_wrap;
      cnt    <= cnt + 1'b1;
      idx_d  <= idx;
      last_d <= (cnt == CW'(TABLE_SIZE - 1));
    end
  end

  // Read in flight flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.issue;
    end
  end

  // Slot valid bits: set on insert, clear on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit) begin
      if (is_insert) begin
        slot_valid[idx_d] <= 1'b1;
      end else if (is_delete) begin
        slot_valid[idx_d] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= ST_OK;
      res_slot   <= 3'(idx_d);
    end else if (cmd.fail) begin
      res_status <= is_insert ? ST_FULL : ST_NOT_FOUND;
      res_slot   <= '0;
    end
  end

  assign status     = res_status;
  assign slot_index = res_slot;

  lpht_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_SIZE)
  ) u_values (
    .clk    (clk),
    .wr_en  (cmd.commit && is_insert),
    .wr_addr(idx_d),
    .wr_data(value),
    .rd_en  (cmd.issue),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

endmodule

`default_nettype wire

@@ rtl/linear_probe_hash_table_core.sv @@
// Linear probe hash table: insert, delete or search of a 16-bit value.
// Each item is captured, divided by TABLE_SIZE for its home slot, then slots
// are probed one a cycle from it until a hit, or a miss or full table.
// One item at a time: next item is taken the cycle after its result leaves.
// Synchronous reset empties every slot at once; no clearing pass.
`default_nettype none

`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] item_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [2:0]       slot_index
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall),
    .out_valid(out_valid)
  );

  lpht_datapath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .item_value(item_value),
    .sts       (sts),
    .status    (status),
    .slot_index(slot_index)
  );

  // A failed request always reports slot zero
  `LPHT_ASSERT_SAME(a_fail_slot_zero, out_valid && (status != ST_OK), slot_index == 3'd0)
  // No new item is taken while a result is pending
  `LPHT_ASSERT_SAME(a_no_accept_busy, out_valid, in_stall)
  // A hit is presented as a result the next cycle
  `LPHT_ASSERT_NEXT(a_commit_result, cmd.commit, out_valid && (status == ST_OK))
  // Hit and miss never fire together
  `LPHT_ASSERT_SAME(a_hit_miss_excl, sts.hit, !sts.miss)

endmodule

`default_nettype wire
